// File: rtl/slsc_pkg.sv
// Shared types, codes and reset values for the sensor link session controller.
// No dependencies; slsc_step, the top level and the checker import this package.
`timescale 1ns / 1ps

package slsc_pkg;

    // Link modes as reported on mode_now; sleep is never held in state
    typedef enum logic [2:0] {
        MODE_CONNECT   = 3'd0,
        MODE_CONNECTED = 3'd1,
        MODE_ALMOST    = 3'd2,
        MODE_READY     = 3'd3,
        MODE_SLEEP     = 3'd4,
        MODE_ACQ       = 3'd5
    } mode_t;

    // Message to transmit
    localparam logic [2:0] KIND_NONE = 3'd0;
    localparam logic [2:0] KIND_CONN = 3'd1;
    localparam logic [2:0] KIND_ACK  = 3'd2;
    localparam logic [2:0] KIND_DET  = 3'd3;
    localparam logic [2:0] KIND_SACK = 3'd4;
    localparam logic [2:0] KIND_COEF = 3'd5;
    localparam logic [2:0] KIND_DATA = 3'd6;

    // Event codes
    localparam logic [1:0] OP_WINDOW  = 2'd0;
    localparam logic [1:0] OP_PACKET  = 2'd1;
    localparam logic [1:0] OP_TIMEOUT = 2'd2;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_BATTERY_FLOOR = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CONNECTED_LIM = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALMOST_LIM    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_READY_LIM     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ACQ_LIM       = 3'd4;

    // Packet framing bytes and command characters
    localparam logic [7:0] FRAME_HEAD = 8'h01;
    localparam logic [7:0] FRAME_TAIL = 8'h04;
    localparam logic [7:0] CMD_CONNECT   = 8'h43; // 'C'
    localparam logic [7:0] CMD_CONNECTED = 8'h63; // 'c'
    localparam logic [7:0] CMD_QUERY     = 8'h71; // 'q'
    localparam logic [7:0] CMD_SLEEP     = 8'h53; // 'S'
    localparam logic [7:0] CMD_ENABLE    = 8'h45; // 'E'
    localparam logic [7:0] CMD_CONTINUE  = 8'h78; // 'x'
    localparam logic [7:0] CMD_HOLD      = 8'h68; // 'h'
    localparam logic [7:0] CMD_JUMP      = 8'h4A; // 'J'

    typedef struct packed {
        logic [11:0] battery_floor;
        logic [15:0] connected_lim;
        logic [15:0] almost_lim;
        logic [15:0] ready_lim;
        logic [15:0] acq_lim;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        battery_floor: 12'd1210,
        connected_lim: 16'd200,
        almost_lim:    16'd1000,
        ready_lim:     16'd400,
        acq_lim:       16'd200
    };

    typedef struct packed {
        mode_t       mode;
        logic        pending;
        logic [15:0] retry;
        logic [31:0] frame;
    } state_t;

    localparam state_t STATE_RESET = '{
        mode:    MODE_CONNECT,
        pending: 1'b0,
        retry:   16'd0,
        frame:   32'd0
    };

    typedef struct packed {
        logic [1:0]  opcode;
        logic [7:0]  first_byte;
        logic [7:0]  last_byte;
        logic [7:0]  command;
        logic [11:0] batt_reading;
    } item_t;

    typedef struct packed {
        logic [2:0]  send_kind;
        logic [31:0] frame_number;
        logic [2:0]  mode_now;
        logic        low_power_wait;
        logic        sleep_reset;
    } result_t;

endpackage

// File: rtl/slsc_in_if.sv
// Input event channel: valid/ready plus the event fields.
// Depends on nothing.
`timescale 1ns / 1ps

interface slsc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [7:0]  first_byte;
    logic [7:0]  last_byte;
    logic [7:0]  command;
    logic [11:0] batt_reading;

    modport source (output valid, opcode, first_byte, last_byte, command, batt_reading,
                    input ready);
    modport sink   (input valid, opcode, first_byte, last_byte, command, batt_reading,
                    output ready);
endinterface

// File: rtl/slsc_out_if.sv
// Result channel: valid/ready plus the result fields.
// Depends on nothing.
`timescale 1ns / 1ps

interface slsc_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  send_kind;
    logic [31:0] frame_number;
    logic [2:0]  mode_now;
    logic        low_power_wait;
    logic        sleep_reset;

    modport source (output valid, send_kind, frame_number, mode_now, low_power_wait,
                    sleep_reset, input ready);
    modport sink   (input valid, send_kind, frame_number, mode_now, low_power_wait,
                    sleep_reset, output ready);
endinterface

// File: rtl/slsc_cfg_if.sv
// Configuration write channel: valid/ready, register index and write data.
// Depends on nothing.
`timescale 1ns / 1ps

interface slsc_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/slsc_step.sv
// Next-state and result logic for one event of the session controller.
// Depends on slsc_pkg.
`timescale 1ns / 1ps

module slsc_step (
    input  slsc_pkg::state_t  cur,
    input  slsc_pkg::cfg_t    cfg,
    input  slsc_pkg::item_t   item,
    output slsc_pkg::state_t  nxt,
    output slsc_pkg::result_t res
);
    import slsc_pkg::*;

    logic        framed;
    logic [15:0] retry_inc;
    logic [31:0] frame_inc;
    logic        is_win;
    logic        is_pkt;
    logic        is_tmo;
    logic        sleep;
    logic        nap;
    logic [2:0]  kind;
    logic [31:0] frame;
    state_t      upd;

    assign framed    = (item.first_byte == FRAME_HEAD) && (item.last_byte == FRAME_TAIL);
    assign retry_inc = cur.retry + 16'd1;
    assign frame_inc = cur.frame + 32'd1;
    assign is_win    = (item.opcode == OP_WINDOW);
    assign is_pkt    = (item.opcode == OP_PACKET);
    assign is_tmo    = (item.opcode == OP_TIMEOUT);

    always_comb
    begin
        upd   = cur;
        kind  = KIND_NONE;
        frame = 32'd0;
        nap   = 1'b0;
        sleep = 1'b0;
        unique case (cur.mode)
            MODE_CONNECT:
            begin
                if (is_win)
                begin
                    kind        = KIND_CONN;
                    upd.pending = 1'b1;
                end
                else if ((is_pkt || is_tmo) && cur.pending)
                begin
                    upd.pending = 1'b0;
                    if (is_pkt)
                    begin
                        if (framed && item.command == CMD_CONNECT)
                            upd.mode = MODE_CONNECTED;
                    end
                    else
                        nap = 1'b1;
                end
            end
            MODE_CONNECTED:
            begin
                if (is_win)
                begin
                    kind        = KIND_ACK;
                    upd.pending = 1'b1;
                end
                else if ((is_pkt || is_tmo) && cur.pending)
                begin
                    upd.pending = 1'b0;
                    if (is_pkt)
                    begin
                        if (framed && item.command == CMD_CONNECTED)
                            upd.mode = MODE_ALMOST;
                    end
                    else
                    begin
                        upd.retry = retry_inc;
                        sleep     = (retry_inc == cfg.connected_lim);
                    end
                end
            end
            MODE_ALMOST:
            begin
                if (is_pkt)
                begin
                    if (framed && item.command == CMD_QUERY)
                    begin
                        kind      = KIND_DET;
                        upd.mode  = MODE_READY;
                        upd.retry = 16'd0;
                    end
                end
                else if (is_tmo)
                begin
                    upd.retry = retry_inc;
                    sleep     = (retry_inc == cfg.almost_lim);
                end
            end
            MODE_READY:
            begin
                if (is_pkt)
                begin
                    if (framed && item.command == CMD_SLEEP)
                    begin
                        kind  = KIND_SACK;
                        sleep = 1'b1;
                    end
                    else if (framed && item.command == CMD_ENABLE)
                    begin
                        kind        = KIND_COEF;
                        upd.mode    = MODE_ACQ;
                        upd.retry   = 16'd0;
                        upd.pending = 1'b0;
                    end
                end
                else if (is_tmo)
                begin
                    upd.retry = retry_inc;
                    sleep     = (retry_inc == cfg.ready_lim);
                end
            end
            default: // acquiring
            begin
                if (is_win)
                begin
                    if (!cur.pending)
                    begin
                        upd.frame = frame_inc;
                        if (item.batt_reading <= cfg.battery_floor)
                            sleep = 1'b1;
                        else
                        begin
                            kind        = KIND_DATA;
                            frame       = frame_inc;
                            upd.pending = 1'b1;
                        end
                    end
                end
                else if (is_pkt && cur.pending)
                begin
                    upd.pending = 1'b0;
                    upd.retry   = 16'd0;
                    // hold-on and jump commands are matched without framing check
                    if (framed && item.command == CMD_CONTINUE)
                        upd.mode = MODE_ACQ;
                    else if (item.command == CMD_HOLD)
                        sleep = 1'b1;
                    else if (item.command == CMD_JUMP)
                        upd.mode = MODE_READY;
                end
                else if (is_tmo && cur.pending)
                begin
                    upd.retry = retry_inc;
                    sleep     = (retry_inc == cfg.acq_lim);
                end
            end
        endcase
    end

    assign nxt = sleep ? STATE_RESET : upd;

    assign res.send_kind      = kind;
    assign res.frame_number   = frame;
    assign res.mode_now       = sleep ? MODE_SLEEP : upd.mode;
    assign res.low_power_wait = nap;
    assign res.sleep_reset    = sleep;

endmodule

// File: rtl/sensor_link_session_controller.sv
// Top level of the sensor link session controller: state, config and result registers.
// Depends on slsc_pkg, slsc_in_if, slsc_out_if, slsc_cfg_if and slsc_step.
//
//   channel  | dir | fields                                                   | word
//   in_ch    | in  | opcode, first_byte, last_byte, command, batt_reading     | one event
//   out_ch   | out | send_kind, frame_number, mode_now, low_power_wait,       | one result
//            |     | sleep_reset                                              |
//   cfg_ch   | in  | index, data                                              | one reg write
//
// One event per cycle while in_ch.ready is high: each accepted word is decoded in the
// same cycle and its result appears in the output register in the next cycle.
// in_ch.ready is high while the output register is empty or being drained.
// A stalled result holds in the output register and blocks only further events.
// cfg_ch.ready is always high. Reset loads register defaults and connect mode.
`timescale 1ns / 1ps

module sensor_link_session_controller (
    input logic clk,
    input logic rst_n,
    slsc_in_if.sink    in_ch,
    slsc_out_if.source out_ch,
    slsc_cfg_if.sink   cfg_ch
);
    import slsc_pkg::*;

    state_t  state_reg;
    state_t  state_next;
    cfg_t    cfg_reg;
    cfg_t    cfg_next;
    result_t res_reg;
    result_t res_next;
    logic    out_valid_reg;
    item_t   item;
    logic    in_fire;
    logic    cfg_fire;

    assign item.opcode       = in_ch.opcode;
    assign item.first_byte   = in_ch.first_byte;
    assign item.last_byte    = in_ch.last_byte;
    assign item.command      = in_ch.command;
    assign item.batt_reading = in_ch.batt_reading;

    assign in_ch.ready  = !out_valid_reg || out_ch.ready;
    assign in_fire      = in_ch.valid && in_ch.ready;
    assign cfg_ch.ready = 1'b1;
    assign cfg_fire     = cfg_ch.valid;

    slsc_step u_step (
        .cur  (state_reg),
        .cfg  (cfg_reg),
        .item (item),
        .nxt  (state_next),
        .res  (res_next)
    );

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_fire)
        begin
            unique case (cfg_ch.index)
                REG_BATTERY_FLOOR: cfg_next.battery_floor = cfg_ch.data[11:0];
                REG_CONNECTED_LIM: cfg_next.connected_lim = cfg_ch.data;
                REG_ALMOST_LIM:    cfg_next.almost_lim    = cfg_ch.data;
                REG_READY_LIM:     cfg_next.ready_lim     = cfg_ch.data;
                REG_ACQ_LIM:       cfg_next.acq_lim       = cfg_ch.data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= STATE_RESET;
            cfg_reg       <= CFG_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
            if (in_fire)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            res_reg <= res_next;
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.send_kind      = res_reg.send_kind;
    assign out_ch.frame_number   = res_reg.frame_number;
    assign out_ch.mode_now       = res_reg.mode_now;
    assign out_ch.low_power_wait = res_reg.low_power_wait;
    assign out_ch.sleep_reset    = res_reg.sleep_reset;

endmodule

// File: rtl/slsc_checker.sv
// Port-level assertions for the session controller, bound to the top level.
// Depends on slsc_pkg and sensor_link_session_controller.
`timescale 1ns / 1ps

module slsc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  send_kind,
    input logic [31:0] frame_number,
    input logic [2:0]  mode_now,
    input logic        low_power_wait,
    input logic        sleep_reset
);
    import slsc_pkg::*;

    // a sleep flag always reports the sleep mode
    a_sleep_mode: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && sleep_reset |-> mode_now == MODE_SLEEP)
        else $error("sleep_reset without sleep mode");

    // frame number is only carried by data frames
    a_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && send_kind != KIND_DATA |-> frame_number == 32'd0)
        else $error("frame_number set on a non-data word");

    // a data frame leaves the block acquiring, never asleep
    a_data_acq: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && send_kind == KIND_DATA |-> mode_now == MODE_ACQ && !sleep_reset)
        else $error("data frame outside acquiring");

    // a nap is only requested from connect mode with nothing to send
    a_nap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && low_power_wait |-> mode_now == MODE_CONNECT && send_kind == KIND_NONE)
        else $error("low_power_wait outside connect timeout");

    // a stalled result word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(send_kind) && $stable(frame_number)
            && $stable(mode_now) && $stable(low_power_wait) && $stable(sleep_reset))
        else $error("stalled result word changed");

endmodule

bind sensor_link_session_controller slsc_checker u_slsc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .send_kind      (out_ch.send_kind),
    .frame_number   (out_ch.frame_number),
    .mode_now       (out_ch.mode_now),
    .low_power_wait (out_ch.low_power_wait),
    .sleep_reset    (out_ch.sleep_reset)
);
